FILE: rtl/deq_pkg.sv
// Shared types, codes and constants of the searchable deque.
package deq_pkg;

  // Field widths fixed by the item format, and the default depth
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned DEPTH_DEF  = 16;

  // Request codes; codes above KIND_FIND are no-ops
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_LEFT  = 3'd0,
    KIND_PUSH_RIGHT = 3'd1,
    KIND_POP_LEFT   = 3'd2,
    KIND_POP_RIGHT  = 3'd3,
    KIND_FIND       = 3'd4
  } kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                    shift_up;    // take the entry of the left neighbor
    logic                    shift_down;  // take the entry of the right neighbor
    logic                    cmp_en;      // capture the compare against value
    logic signed [VAL_W-1:0] value;       // push value or search key
  } cell_cmd_t;

endpackage

FILE: rtl/deq_if.sv
// Valid/ready channel interfaces for requests and results of the deque.

// Request channel
interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::KIND_W-1:0]          kind;
  logic signed [deq_pkg::VAL_W-1:0]    value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// Result channel
interface deq_out_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::STATUS_W-1:0]        status;
  logic signed [deq_pkg::VAL_W-1:0]    popped_value;
  logic [deq_pkg::POS_W-1:0]           position;

  modport source (output valid, output status, output popped_value, output position,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input position,
                  output ready);
endinterface

FILE: rtl/deq_cell.sv
// One storage cell of the deque chain: holds one entry and its match flag.
module deq_cell (
  input  logic                                 clk_i,
  input  deq_pkg::cell_cmd_t                   cmd_i,
  input  logic                                 we_i,
  input  logic signed [deq_pkg::VAL_W-1:0]     lower_i,
  input  logic signed [deq_pkg::VAL_W-1:0]     upper_i,
  output logic signed [deq_pkg::VAL_W-1:0]     data_o,
  output logic                                 match_o
);
  import deq_pkg::*;

  logic signed [VAL_W-1:0] data_q, data_d;
  logic                    match_q, match_d;

  // Entry update: shift toward the right end, toward the left end, or load
  always_comb begin
    data_d = data_q;
    if (cmd_i.shift_up) begin
      data_d = lower_i;
    end else if (cmd_i.shift_down) begin
      data_d = upper_i;
    end else if (we_i) begin
      data_d = cmd_i.value;
    end
  end

  // Local compare, held through the scan
  always_comb begin
    match_d = match_q;
    if (cmd_i.cmp_en) begin
      match_d = (data_q == cmd_i.value);
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

FILE: rtl/double_ended_queue_with_search.sv
// Bounded deque of signed 32-bit values with first-match search.
// Requests arrive on in_i (kind, value) and each gives one result on out_o
// (status, popped_value, position); both channels use valid/ready.
// Storage is a row of DEPTH cells, cell k holding the entry k places from
// the left end. A push at the left shifts every cell one place right, a pop
// at the left shifts every cell one place left; a push at the right writes
// only the cell at the fill level, a pop at the right reads the cell below it.
// Push and pop results are registered and show on out_o the cycle after the
// request is accepted, and a new request can be taken in that same cycle if
// out_o is ready, so one item per cycle is sustained while out_o does not stall.
// A find loads a match flag in every cell in the accept cycle, then a scan
// counter walks the flags from the left end one cell per cycle; the find
// answers at the first set flag, or with ST_NOT_FOUND at the last held entry.
// A find on an empty deque skips the scan; its result is registered like a pop's.
// Reset empties the deque; entry contents are not cleared and never read
// before being pushed. While a result waits on a stalled out_o the result
// register holds it and no new request is taken.
module double_ended_queue_with_search #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_in_if.sink    in_i,
  deq_out_if.source out_o
);
  import deq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  state_e                   state_q, state_d;
  logic [CntW-1:0]          fill_q, fill_d;
  logic [IdxW-1:0]          scan_q, scan_d;
  logic                     out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]      out_status_q, out_status_d;
  logic signed [VAL_W-1:0]  out_pop_q, out_pop_d;
  logic [POS_W-1:0]         out_pos_q, out_pos_d;

  cell_cmd_t                cmd;
  logic [DEPTH-1:0]         we;
  logic [DEPTH-1:0]         match;
  logic signed [VAL_W-1:0]  cell_data [DEPTH];
  logic signed [VAL_W-1:0]  right_data;

  logic in_fire, out_free, empty, full, hit, last, scan_done;

  // Handshake and status terms
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_fire   = in_i.valid && in_i.ready;
  assign empty     = (fill_q == '0);
  assign full      = (fill_q == CntW'(DEPTH));
  assign hit       = match[scan_q];
  assign last      = ((CntW'(scan_q) + CntW'(1)) == fill_q);
  assign scan_done = hit || last;

  // Chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = cmd.value;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    deq_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .we_i    (we[i]),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i]),
      .match_o (match[i])
    );
  end

  // Rightmost held entry: the cell just below the fill level drives the bus
  always_comb begin
    right_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (fill_q == CntW'(i + 1)) begin
        right_data = right_data | cell_data[i];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (in_i.kind == KIND_FIND) && !empty) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done && out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control and result
  always_comb begin
    cmd          = '0;
    cmd.value    = in_i.value;
    we           = '0;
    fill_d       = fill_q;
    scan_d       = scan_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_pop_d    = out_pop_q;
    out_pos_d    = out_pos_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_pop_d    = '0;
          out_pos_d    = '0;
          case (in_i.kind)
            KIND_PUSH_LEFT: begin
              if (full) begin
                out_status_d = ST_FULL;
              end else begin
                cmd.shift_up = 1'b1;
                fill_d       = fill_q + CntW'(1);
              end
            end
            KIND_PUSH_RIGHT: begin
              if (full) begin
                out_status_d = ST_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  we[i] = (fill_q == CntW'(i));
                end
                fill_d = fill_q + CntW'(1);
              end
            end
            KIND_POP_LEFT: begin
              if (empty) begin
                out_status_d = ST_EMPTY;
              end else begin
                out_pop_d      = cell_data[0];
                cmd.shift_down = 1'b1;
                fill_d         = fill_q - CntW'(1);
              end
            end
            KIND_POP_RIGHT: begin
              if (empty) begin
                out_status_d = ST_EMPTY;
              end else begin
                out_pop_d = right_data;
                fill_d    = fill_q - CntW'(1);
              end
            end
            KIND_FIND: begin
              if (empty) begin
                out_status_d = ST_NOT_FOUND;
              end else begin
                // result comes out of the scan
                out_valid_d = 1'b0;
                cmd.cmp_en  = 1'b1;
                scan_d      = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = hit ? ST_OK : ST_NOT_FOUND;
            out_pop_d    = '0;
            out_pos_d    = hit ? POS_W'(scan_q) : '0;
          end
        end else begin
          scan_d = scan_q + IdxW'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_pop_q    <= out_pop_d;
    out_pos_q    <= out_pos_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.popped_value = out_pop_q;
  assign out_o.position     = out_pos_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(DEPTH))
    else $error("fill level beyond depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CntW'(scan_q) < fill_q))
    else $error("scan beyond held entries");

  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !in_i.ready)
    else $error("request taken during a scan");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !full && (in_i.kind == KIND_PUSH_LEFT || in_i.kind == KIND_PUSH_RIGHT))
      |=> (fill_q == $past(fill_q) + CntW'(1)))
    else $error("push did not grow the deque");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !empty && (in_i.kind == KIND_POP_LEFT || in_i.kind == KIND_POP_RIGHT))
      |=> (fill_q == $past(fill_q) - CntW'(1)))
    else $error("pop did not shrink the deque");
`endif

endmodule

FILE: sim/tb_double_ended_queue_with_search.sv
`timescale 1ns / 1ps
// Self-checking testbench for the searchable deque: directed and random requests, in-order checks.
module tb_double_ended_queue_with_search;
  import deq_pkg::*;

  localparam int unsigned DEPTH          = DEPTH_DEF;
  localparam int unsigned CLK_HALF       = 4;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned TIMEOUT_NS     = 2_000_000;
  localparam int unsigned IDLE_PCT       = 9;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AFTER     = 80;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned MAX_REPORTS    = 100;

  // First of the unused request codes (no-ops)
  localparam logic [KIND_W-1:0] KIND_NOP_LO = 3'd5;

  // Burst shapes of the random stimulus
  localparam int unsigned BURST_FILL   = 0;
  localparam int unsigned BURST_DRAIN  = 1;
  localparam int unsigned BURST_MIXED  = 2;
  localparam int unsigned BURST_SEARCH = 3;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
  } deq_req_t;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] popped_value;
    logic [POS_W-1:0]        position;
  } deq_result_t;

  logic clk;
  logic rst_n;

  deq_in_if  in_if();
  deq_out_if out_if();

  double_ended_queue_with_search #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow deque: circular store, left index, fill level
  logic signed [VAL_W-1:0] shadow_store [DEPTH];
  logic [POS_W-1:0]        shadow_left;
  logic [POS_W:0]          shadow_fill;

  deq_req_t                pending_req_q [$];
  deq_result_t             expected_q [$];
  logic signed [VAL_W-1:0] key_pool [$];

  int unsigned queued_cnt;
  int unsigned accepted_cnt;
  int unsigned checked_cnt;
  int unsigned err_cnt;
  logic        in_taken;
  logic        calm;
  logic        rx_hold;

  // Clock
  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  task automatic report_mismatch(input string what);
    if (err_cnt < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // Apply one request to the shadow deque and return its result.
  // DEPTH is a power of two, so 4-bit index arithmetic wraps the ring.
  function automatic deq_result_t deque_apply(input deq_req_t req);
    deq_result_t      res;
    logic [POS_W-1:0] slot;
    logic             hit;
    int               i;
    res.status       = ST_OK;
    res.popped_value = '0;
    res.position     = '0;
    hit              = 1'b0;
    case (req.kind)
      KIND_PUSH_LEFT: begin
        if (shadow_fill == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_left               = shadow_left - 1'b1;
          shadow_store[shadow_left] = req.value;
          shadow_fill               = shadow_fill + 1'b1;
        end
      end
      KIND_PUSH_RIGHT: begin
        if (shadow_fill == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot               = shadow_left + shadow_fill[POS_W-1:0];
          shadow_store[slot] = req.value;
          shadow_fill        = shadow_fill + 1'b1;
        end
      end
      KIND_POP_LEFT: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped_value = shadow_store[shadow_left];
          shadow_left      = shadow_left + 1'b1;
          shadow_fill      = shadow_fill - 1'b1;
        end
      end
      KIND_POP_RIGHT: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot             = shadow_left + shadow_fill[POS_W-1:0] - 1'b1;
          res.popped_value = shadow_store[slot];
          shadow_fill      = shadow_fill - 1'b1;
        end
      end
      KIND_FIND: begin
        // leftmost match wins
        res.status = ST_NOT_FOUND;
        for (i = 0; i < DEPTH; i++) begin
          slot = shadow_left + i[POS_W-1:0];
          if (!hit && i < shadow_fill && shadow_store[slot] == req.value) begin
            hit          = 1'b1;
            res.status   = ST_OK;
            res.position = i[POS_W-1:0];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Request driver: holds an item until accepted, idles at random
  always @(negedge clk) begin : drive_requests
    deq_req_t nxt;
    if (rst_n) begin
      if (!in_if.valid || in_taken) begin
        if (pending_req_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt          = pending_req_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.kind  <= nxt.kind;
          in_if.value <= nxt.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= !rx_hold && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result monitor: check results first, then predict newly accepted items
  always @(posedge clk) begin : check_results
    deq_result_t want;
    deq_req_t    got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d popped %0d position %0d",
                                    out_if.status, out_if.popped_value, out_if.position));
        end else begin
          want = expected_q.pop_front();
          if (out_if.status !== want.status)
            report_mismatch($sformatf("item %0d status %0d, want %0d",
                                      checked_cnt, out_if.status, want.status));
          if (out_if.popped_value !== want.popped_value)
            report_mismatch($sformatf("item %0d popped_value %0d, want %0d",
                                      checked_cnt, out_if.popped_value, want.popped_value));
          if (out_if.position !== want.position)
            report_mismatch($sformatf("item %0d position %0d, want %0d",
                                      checked_cnt, out_if.position, want.position));
          checked_cnt++;
        end
      end
      in_taken = in_if.valid && in_if.ready;
      if (in_taken) begin
        got.kind  = in_if.kind;
        got.value = in_if.value;
        expected_q.push_back(deque_apply(got));
        accepted_cnt++;
      end
    end
  end

  // Long result back-pressure while requests keep coming
  initial begin : rx_backpressure
    rx_hold = 1'b0;
    wait (accepted_cnt >= HOLD_AFTER);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_double_ended_queue_with_search: FAIL");
    $finish;
  end

  task automatic queue_req(input logic [KIND_W-1:0] kind, input logic signed [VAL_W-1:0] value);
    deq_req_t r;
    r.kind  = kind;
    r.value = value;
    pending_req_q.push_back(r);
    queued_cnt++;
    // remember recent pushes so that searches mostly hit
    if (kind == KIND_PUSH_LEFT || kind == KIND_PUSH_RIGHT) begin
      key_pool.push_back(value);
      if (key_pool.size() > DEPTH) void'(key_pool.pop_front());
    end
  endtask

  // Extremes, a small set that breeds duplicates, or fully random
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom_range(7);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(3) != 0)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    return pick_value();
  endfunction

  task automatic gen_burst(input int unsigned mode, input int unsigned len);
    int unsigned       i;
    int unsigned       r;
    logic [KIND_W-1:0] knd;
    for (i = 0; i < len; i++) begin
      r = $urandom_range(19);
      case (mode)
        BURST_FILL:   knd = (r < 4) ? KIND_FIND : (r[0] ? KIND_PUSH_RIGHT : KIND_PUSH_LEFT);
        BURST_DRAIN:  knd = (r < 4) ? KIND_FIND : (r[0] ? KIND_POP_RIGHT : KIND_POP_LEFT);
        BURST_SEARCH: knd = (r < 14) ? KIND_FIND : (r[0] ? KIND_PUSH_RIGHT : KIND_POP_LEFT);
        default:      knd = (r >= 17) ? KIND_W'(KIND_NOP_LO + (r - 17)) : KIND_W'(r % 5);
      endcase
      queue_req(knd, (knd == KIND_FIND) ? pick_key() : pick_value());
    end
  endtask

  task automatic gen_random(input int unsigned count);
    int unsigned target;
    int unsigned r;
    target = queued_cnt + count;
    while (queued_cnt < target) begin
      r = $urandom_range(9);
      gen_burst((r < 3) ? BURST_FILL : (r < 6) ? BURST_DRAIN : (r < 8) ? BURST_MIXED : BURST_SEARCH,
                $urandom_range(6, 22));
    end
  endtask

  // Fill to the brim from both ends, overflow, find the far right, drain past empty
  task automatic fill_and_drain();
    logic signed [VAL_W-1:0] v;
    int unsigned             i;
    for (i = 0; i < DEPTH; i++) begin
      v = $urandom();
      queue_req(i[0] ? KIND_PUSH_RIGHT : KIND_PUSH_LEFT, v);
    end
    queue_req(KIND_PUSH_LEFT, pick_value());
    queue_req(KIND_PUSH_RIGHT, pick_value());
    queue_req(KIND_FIND, v);
    for (i = 0; i <= DEPTH; i++) queue_req(i[0] ? KIND_POP_RIGHT : KIND_POP_LEFT, $urandom());
  endtask

  task automatic wait_drained();
    wait (accepted_cnt == queued_cnt && checked_cnt == queued_cnt);
  endtask

  initial begin : stimulus
    rst_n        = 1'b0;
    calm         = 1'b0;
    in_taken     = 1'b0;
    in_if.valid  = 1'b0;
    in_if.kind   = KIND_PUSH_LEFT;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    shadow_left  = '0;
    shadow_fill  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty deque, extremes, duplicates, no-op codes
    queue_req(KIND_POP_LEFT, 32'h1234_5678);
    queue_req(KIND_POP_RIGHT, 32'hFFFF_FFFF);
    queue_req(KIND_FIND, 32'h0000_0000);
    queue_req(KIND_PUSH_LEFT, 32'h8000_0000);
    queue_req(KIND_PUSH_RIGHT, 32'h7FFF_FFFF);
    queue_req(KIND_PUSH_LEFT, 32'hFFFF_FFFF);
    queue_req(KIND_PUSH_RIGHT, 32'h0000_0000);
    queue_req(KIND_PUSH_RIGHT, 32'hFFFF_FFFF);
    queue_req(KIND_FIND, 32'h7FFF_FFFF);
    queue_req(KIND_FIND, 32'hFFFF_FFFF);
    queue_req(KIND_FIND, 32'h5A5A_5A5A);
    queue_req(KIND_NOP_LO, 32'hAAAA_AAAA);
    queue_req(KIND_NOP_LO + 3'd1, 32'h5555_5555);
    queue_req(KIND_NOP_LO + 3'd2, 32'hFFFF_FFFF);
    queue_req(KIND_POP_LEFT, 32'h0000_0000);
    queue_req(KIND_POP_RIGHT, 32'h0000_0000);
    queue_req(KIND_POP_RIGHT, 32'h0000_0000);
    queue_req(KIND_POP_LEFT, 32'h0000_0000);
    queue_req(KIND_POP_LEFT, 32'h0000_0000);
    queue_req(KIND_POP_LEFT, 32'h0000_0000);
    // sender pauses until every result is back
    wait_drained();

    // Random, with idling on both sides and the long receiver hold
    fill_and_drain();
    gen_random(300);
    wait_drained();

    // Random, no idling at all
    calm = 1'b1;
    gen_random(150);
    wait_drained();

    calm = 1'b0;
    gen_random(260);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb_double_ended_queue_with_search: PASS");
    end else begin
      $display("tb_double_ended_queue_with_search: FAIL");
    end
    $finish;
  end

endmodule

FILE: double_ended_queue_with_search.f
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_cell.sv
rtl/double_ended_queue_with_search.sv
sim/tb_double_ended_queue_with_search.sv
